### hw/rtl/ccr_pkg.sv
// Package for the circle canvas rasterizer: command and response words,
// register map, kind codes, action codes and derived arithmetic widths.
// No dependencies.
package ccr_pkg;

    // Canvas geometry and fixed point format
    localparam int MAX_SIDE  = 256;
    localparam int FRAC_BITS = 8;
    localparam int SIDE_W    = $clog2(MAX_SIDE);
    localparam int MEM_AW    = 2 * SIDE_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    // Field widths fixed by the interface
    localparam int COORD_W = 20;
    localparam int CFG_W   = 9;

    // Pixel offset minus a Q format coordinate, and squared distances
    localparam int POS_W  = SIDE_W + FRAC_BITS;
    localparam int DIFF_W = ((POS_W > COORD_W) ? POS_W : COORD_W) + 1;
    localparam int SQ_W   = 2 * DIFF_W - 1;

    // Actions
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Shape kinds
    localparam logic [7:0] KIND_OUTLINE = 8'h63;
    localparam logic [7:0] KIND_FILLED  = 8'h43;

    // Register map, index = paddr / 4
    localparam int          APB_AW      = 4;
    localparam logic [1:0]  REG_WIDTH   = 2'd0;
    localparam logic [1:0]  REG_HEIGHT  = 2'd1;
    localparam logic [1:0]  REG_BG      = 2'd2;
    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(1);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(1);
    localparam logic [7:0]       BG_RST     = 8'd32;

    typedef struct packed {
        logic [1:0]                action;
        logic [7:0]                kind_byte;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] radius_value;
        logic [7:0]                paint_byte;
        logic [7:0]                read_column;
        logic [7:0]                read_row;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cell_byte;
        logic       error_flag;
    } rsp_t;

endpackage

### hw/rtl/circle_canvas_rasterizer.sv
// Circle canvas rasterizer top level: sequencer, shared squaring unit,
// canvas memory and configuration port. Depends on ccr_pkg.
//
// One command word is taken at a time; cmd_ready is high only while the
// sequencer is idle, and the response register lets the next command in
// while the previous response waits. A clear writes every canvas cell, one
// per cycle. A draw over an active canvas of W by H uses the single
// squaring multiplier to form r^2 and (r-1)^2 once, then dy^2 once per row
// and dx^2 once per pixel, and the memory write port takes one pixel per
// cycle. A read goes through the read state to the response; a rejected
// draw or a no-op goes straight to the response.
module circle_canvas_rasterizer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  ccr_pkg::cmd_t              cmd,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output ccr_pkg::rsp_t              rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ccr_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ccr_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CLEAR   = 4'd1;
    localparam logic [3:0] ST_SETUP_R = 4'd2;
    localparam logic [3:0] ST_SETUP_I = 4'd3;
    localparam logic [3:0] ST_ROW     = 4'd4;
    localparam logic [3:0] ST_PIX     = 4'd5;
    localparam logic [3:0] ST_DRAIN   = 4'd6;
    localparam logic [3:0] ST_READ    = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    localparam logic [SIDE_W-1:0] SIDE_LAST = SIDE_W'(MAX_SIDE - 1);
    localparam logic [SIDE_W-1:0] ALL_ONES  = '1;
    localparam logic signed [DIFF_W-1:0] ONE = DIFF_W'(1 << FRAC_BITS);

    // Configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [7:0]       bg_reg;

    // Sequencer and item registers
    logic [3:0]                state_reg;
    logic [3:0]                state_next;
    logic [SIDE_W-1:0]         x_reg;
    logic [SIDE_W-1:0]         y_reg;
    logic [SIDE_W-1:0]         last_x_reg;
    logic [SIDE_W-1:0]         last_y_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [COORD_W-1:0] rad_reg;
    logic [7:0]                paint_reg;
    logic                      filled_reg;
    logic                      any_inner_reg;
    logic                      is_read_reg;
    logic                      in_range_reg;
    logic                      err_reg;
    logic [SQ_W-1:0]           r2_reg;
    logic [SQ_W-1:0]           in2_reg;
    logic [SQ_W-1:0]           dy2_reg;

    // Pixel pipeline stage after the multiplier
    logic              pv_reg;
    logic [SIDE_W-1:0] px_reg;
    logic [SIDE_W-1:0] py_reg;
    logic [SQ_W-1:0]   sq_reg;

    // Response register
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    // Canvas memory
    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    logic                     cmd_fire;
    logic                     cfg_wr;
    logic                     draw_bad;
    logic [SIDE_W-1:0]        mul_coord;
    logic signed [DIFF_W-1:0] mul_pos;
    logic signed [DIFF_W-1:0] mul_op;
    logic signed [2*DIFF_W-1:0] mul_prod;
    logic [SQ_W-1:0]          sq_now;
    logic [SQ_W-1:0]          d2;
    logic                     hit;
    logic [SIDE_W-1:0]        last_w;
    logic [SIDE_W-1:0]        last_h;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;

    // Bounded side minus one: zero acts as one, oversize saturates
    always_comb
    begin
        if (width_reg == '0)
            last_w = '0;
        else if (width_reg > CFG_W'(MAX_SIDE))
            last_w = SIDE_LAST;
        else
            last_w = SIDE_W'(width_reg - CFG_W'(1));
        if (height_reg == '0)
            last_h = '0;
        else if (height_reg > CFG_W'(MAX_SIDE))
            last_h = SIDE_LAST;
        else
            last_h = SIDE_W'(height_reg - CFG_W'(1));
    end

    assign draw_bad = (cmd.radius_value <= 0) ||
                      ((cmd.kind_byte != KIND_OUTLINE) && (cmd.kind_byte != KIND_FILLED));

    // Shared squaring unit: pick the operand for this step
    assign mul_coord = (state_reg == ST_ROW) ? y_reg : x_reg;
    assign mul_pos   = DIFF_W'(signed'({1'b0, mul_coord})) <<< FRAC_BITS;

    always_comb
    begin
        case (state_reg)
            ST_SETUP_R: mul_op = DIFF_W'(rad_reg);
            ST_SETUP_I: mul_op = DIFF_W'(rad_reg) - ONE;
            ST_ROW:     mul_op = mul_pos - DIFF_W'(cy_reg);
            default:    mul_op = mul_pos - DIFF_W'(cx_reg);
        endcase
    end

    assign mul_prod = mul_op * mul_op;
    assign sq_now   = mul_prod[SQ_W-1:0];

    // Second pixel stage: add dy^2 and test against the radii
    assign d2  = sq_reg + dy2_reg;
    assign hit = pv_reg && (d2 <= r2_reg) && (filled_reg || any_inner_reg || (d2 > in2_reg));

    assign mem_we    = (state_reg == ST_CLEAR) || hit;
    assign mem_waddr = (state_reg == ST_CLEAR) ? {y_reg, x_reg} : {py_reg, px_reg};
    assign mem_wdata = (state_reg == ST_CLEAR) ? bg_reg : paint_reg;

    // Canvas memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[{y_reg, x_reg}];
    end

    // Next sequencer state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.action)
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_DRAW:  state_next = draw_bad ? ST_DONE : ST_SETUP_R;
                        ACT_READ:  state_next = ST_READ;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if ((x_reg == ALL_ONES) && (y_reg == ALL_ONES))
                    state_next = ST_DONE;
            end
            ST_SETUP_R: state_next = ST_SETUP_I;
            ST_SETUP_I: state_next = ST_ROW;
            ST_ROW:     state_next = ST_PIX;
            ST_PIX:
            begin
                if (x_reg == last_x_reg)
                    state_next = (y_reg == last_y_reg) ? ST_DRAIN : ST_ROW;
            end
            ST_DRAIN:   state_next = ST_DONE;
            ST_READ:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            err_reg       <= 1'b0;
            pv_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            bg_reg        <= BG_RST;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= (state_reg == ST_PIX);

            // Update the sticky error on accept
            if (cmd_fire && (cmd.action == ACT_CLEAR))
                err_reg <= 1'b0;
            else if (cmd_fire && (cmd.action == ACT_DRAW) && draw_bad)
                err_reg <= 1'b1;

            // Hand over the response word
            if ((state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready))
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            // Take register writes
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                    REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                    REG_BG:     bg_reg     <= pwdata[7:0];
                    default:    ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        px_reg <= x_reg;
        py_reg <= y_reg;
        sq_reg <= sq_now;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    cx_reg        <= cmd.center_x;
                    cy_reg        <= cmd.center_y;
                    rad_reg       <= cmd.radius_value;
                    paint_reg     <= cmd.paint_byte;
                    filled_reg    <= (cmd.kind_byte == KIND_FILLED);
                    any_inner_reg <= (DIFF_W'(cmd.radius_value) < ONE);
                    is_read_reg   <= (cmd.action == ACT_READ);
                    in_range_reg  <= ({1'b0, cmd.read_column} < 9'(MAX_SIDE)) &&
                                     ({1'b0, cmd.read_row} < 9'(MAX_SIDE));
                    last_x_reg    <= last_w;
                    last_y_reg    <= last_h;
                    if (cmd.action == ACT_READ)
                    begin
                        x_reg <= SIDE_W'(cmd.read_column);
                        y_reg <= SIDE_W'(cmd.read_row);
                    end
                    else
                    begin
                        x_reg <= '0;
                        y_reg <= '0;
                    end
                end
            end
            ST_CLEAR:
            begin
                // Sweep every cell, row by row
                x_reg <= x_reg + SIDE_W'(1);
                if (x_reg == ALL_ONES)
                    y_reg <= y_reg + SIDE_W'(1);
            end
            ST_SETUP_R: r2_reg  <= sq_now;
            ST_SETUP_I: in2_reg <= sq_now;
            ST_ROW:
            begin
                dy2_reg <= sq_now;
                x_reg   <= '0;
            end
            ST_PIX:
            begin
                if (x_reg == last_x_reg)
                begin
                    if (y_reg != last_y_reg)
                        y_reg <= y_reg + SIDE_W'(1);
                end
                else
                begin
                    x_reg <= x_reg + SIDE_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_reg.cell_byte  <= (is_read_reg && in_range_reg) ? rdata_reg : 8'd0;
                    rsp_reg.error_flag <= err_reg;
                end
            end
            default: ;
        endcase
    end

    // Register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_BG:     prdata = 32'(bg_reg);
            default:    prdata = 32'd0;
        endcase
    end

`ifndef ASSERT_OFF
    // Canvas writes come only from the clear sweep or the pixel stage
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_CLEAR) || pv_reg))
        else $error("canvas write outside clear or draw");

    // A painted pixel lies inside the active canvas
    assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> ((px_reg <= last_x_reg) && (py_reg <= last_y_reg)))
        else $error("pixel write outside active canvas");

    // The sticky error stays low through a clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !err_reg)
        else $error("error flag set during clear");

    // The pixel stage drains before the sequencer goes idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pv_reg)
        else $error("pixel stage busy while idle");
`endif

endmodule
